FILE: rtl/p2if_pkg.sv
// Shared constants, types and register map for the phase to frequency block.
`timescale 1ns / 1ps
`default_nettype none
package p2if_pkg;

  // Phase format and derived fixed-point constants
  localparam int PHASE_FRAC_BITS = 13;
  localparam int PHASE_W         = 16;
  localparam int GAIN_W          = 24;
  localparam int FREQ_W          = 23;
  // Differences and sums of differences stay well inside 24 bits for any
  // phase format from 8 to 20 fractional bits.
  localparam int D_W             = 24;
  localparam int MAG_W           = D_W - 1;
  localparam int PROD_W          = MAG_W + GAIN_W;
  localparam int ROUND_SH        = PHASE_FRAC_BITS + 5;

  localparam longint PI_Q24 = 64'sd52707179;
  localparam longint PI_QL  =
    (PI_Q24 + (64'sd1 <<< (23 - PHASE_FRAC_BITS))) >>> (24 - PHASE_FRAC_BITS);

  localparam logic signed [D_W-1:0] PI_Q     = D_W'(PI_QL);
  localparam logic signed [D_W-1:0] TWO_PI_Q = D_W'(2 * PI_QL);

  localparam logic [FREQ_W-1:0] FREQ_MAX = FREQ_W'(3294199);

  // Configuration register map (word index = paddr[2])
  localparam int          CFG_AW        = 3;
  localparam logic        REG_FREQ_GAIN = 1'b0;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(40744);

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;
  localparam int CNT_W      = 4;

  typedef struct packed {
    logic signed [FREQ_W-1:0] freq;
    logic                     too_short;
    logic                     fin;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/phase_to_instantaneous_frequency.sv
// Top level: phase stream to instantaneous frequency, with APB gain register.
// An accepted sample is registered in stage A, then stage B, then in the result
// queue. One input transaction per cycle while in_tready is high; one result per
// cycle leaves while out_tready is high. An end-of-stream sample may give two
// results; an 8-entry result queue absorbs them, and in_tready drops only when
// queue plus pipeline could overflow. Synchronous active-low reset clears state,
// pipeline and queue; gain -> 40744.
`timescale 1ns / 1ps
`default_nettype none
module phase_to_instantaneous_frequency
  import p2if_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [15:0]       in_tdata,    // [15:0] phase_sample
  input  wire logic              in_tlast,    // end_of_stream
  // result stream
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [23:0]            out_tdata,   // [22:0] freq_hz, [23] zero pad
  output logic                   out_tuser,   // [0] too_short
  output logic                   out_tlast,   // final_result
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  typedef enum logic [1:0] {
    IDX_FIRST,
    IDX_SECOND,
    IDX_STEADY
  } idx_t;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  logic [GAIN_W-1:0]         gain_r;
  idx_t                      idx_r, idx_nxt;
  logic signed [PHASE_W-1:0] prior_phase_r;
  logic signed [D_W-1:0]     prior_diff_r, prior_diff_nxt;

  // stage A: operands (doubled single difference, or sum of two)
  logic [1:0]                a_cnt_r, a_cnt_nxt;
  logic signed [D_W-1:0]     a_op0_r, a_op0_nxt;
  logic signed [D_W-1:0]     a_op1_r, a_op1_nxt;
  logic                      a_short0_r, a_short0_nxt;
  logic                      a_fin0_r, a_fin0_nxt;

  // stage B: magnitude products
  logic [1:0]                b_cnt_r;
  logic [PROD_W-1:0]         b_prod0_r, b_prod1_r;
  logic                      b_neg0_r, b_neg1_r;
  logic                      b_short0_r, b_fin0_r;

  // result queue
  res_t                      fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]        wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]          cnt_r;

  // ---------------------------------------------------------------------
  // Input side: clamp, wrap, sequence tracking
  // ---------------------------------------------------------------------
  logic                      in_acc;
  logic signed [D_W-1:0]     p_ext, p_cl, raw_diff, d;
  logic signed [D_W-1:0]     d2, dsum;
  logic [CNT_W-1:0]          pending;

  assign in_acc  = in_tvalid && in_tready;
  assign pending = cnt_r + CNT_W'(a_cnt_r) + CNT_W'(b_cnt_r);
  // room for the worst case of two more results
  assign in_tready = (pending <= CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    p_ext = D_W'(signed'(in_tdata));
    if (p_ext > PI_Q) begin
      p_cl = PI_Q;
    end else if (p_ext < -PI_Q) begin
      p_cl = -PI_Q;
    end else begin
      p_cl = p_ext;
    end
    raw_diff = p_cl - D_W'(prior_phase_r);
    if (raw_diff > PI_Q) begin
      d = raw_diff - TWO_PI_Q;
    end else if (raw_diff < -PI_Q) begin
      d = raw_diff + TWO_PI_Q;
    end else begin
      d = raw_diff;
    end
    // single differences are doubled so both kinds share one rounding shift
    d2   = d <<< 1;
    dsum = prior_diff_r + d;
  end

  always_comb begin
    idx_nxt        = idx_r;
    prior_diff_nxt = prior_diff_r;
    a_cnt_nxt      = 2'd0;
    a_op0_nxt      = '0;
    a_op1_nxt      = d2;
    a_short0_nxt   = 1'b0;
    a_fin0_nxt     = 1'b0;
    unique case (idx_r)
      IDX_FIRST: begin
        if (in_tlast) begin
          a_cnt_nxt    = 2'd1;
          a_short0_nxt = 1'b1;
          a_fin0_nxt   = 1'b1;
        end else begin
          idx_nxt = IDX_SECOND;
        end
      end
      IDX_SECOND: begin
        a_cnt_nxt = 2'd1;
        if (in_tlast) begin
          idx_nxt      = IDX_FIRST;
          a_short0_nxt = 1'b1;
          a_fin0_nxt   = 1'b1;
        end else begin
          idx_nxt        = IDX_STEADY;
          prior_diff_nxt = d;
          a_op0_nxt      = d2;
        end
      end
      IDX_STEADY: begin
        prior_diff_nxt = d;
        a_op0_nxt      = dsum;
        if (in_tlast) begin
          idx_nxt   = IDX_FIRST;
          a_cnt_nxt = 2'd2;
        end else begin
          a_cnt_nxt = 2'd1;
        end
      end
      default: begin
        idx_nxt = IDX_FIRST;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage B: sign/magnitude split and gain multiply
  // ---------------------------------------------------------------------
  logic signed [D_W-1:0] abs0_s, abs1_s;
  logic [MAG_W-1:0]      mag0, mag1;

  always_comb begin
    abs0_s = a_op0_r[D_W-1] ? -a_op0_r : a_op0_r;
    abs1_s = a_op1_r[D_W-1] ? -a_op1_r : a_op1_r;
    mag0   = abs0_s[MAG_W-1:0];
    mag1   = abs1_s[MAG_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage C: round half away from zero, saturate, restore sign
  // ---------------------------------------------------------------------
  function automatic logic signed [FREQ_W-1:0] to_freq(input logic [PROD_W-1:0] prod,
                                                       input logic neg);
    logic [PROD_W:0]    rnd;
    logic [PROD_W:0]    shifted;
    logic [FREQ_W-1:0]  mag;
    rnd     = {1'b0, prod} + ((PROD_W + 1)'(1) << (ROUND_SH - 1));
    shifted = rnd >> ROUND_SH;
    if (shifted > (PROD_W + 1)'(FREQ_MAX)) begin
      mag = FREQ_MAX;
    end else begin
      mag = shifted[FREQ_W-1:0];
    end
    return neg ? -signed'(mag) : signed'(mag);
  endfunction

  res_t res0, res1;

  always_comb begin
    res0.freq      = to_freq(b_prod0_r, b_neg0_r);
    res0.too_short = b_short0_r;
    res0.fin       = b_fin0_r;
    res1.freq      = to_freq(b_prod1_r, b_neg1_r);
    res1.too_short = 1'b0;
    res1.fin       = 1'b1;
  end

  // ---------------------------------------------------------------------
  // Queue control
  // ---------------------------------------------------------------------
  logic               pop;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [FIFO_AW-1:0] wr_ptr1;

  assign pop     = out_tvalid && out_tready;
  assign cnt_nxt = cnt_r + CNT_W'(b_cnt_r) - CNT_W'(pop);
  assign wr_ptr1 = wr_ptr_r + FIFO_AW'(1);

  // ---------------------------------------------------------------------
  // Sequential logic
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= GAIN_RESET;
      idx_r         <= IDX_FIRST;
      prior_phase_r <= '0;
      prior_diff_r  <= '0;
      a_cnt_r       <= 2'd0;
      b_cnt_r       <= 2'd0;
      wr_ptr_r      <= '0;
      rd_ptr_r      <= '0;
      cnt_r         <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
          && (cfg_paddr[2] == REG_FREQ_GAIN)) begin
        gain_r <= cfg_pwdata[GAIN_W-1:0];
      end
      if (in_acc) begin
        idx_r         <= idx_nxt;
        prior_phase_r <= p_cl[PHASE_W-1:0];
        prior_diff_r  <= prior_diff_nxt;
        a_cnt_r       <= a_cnt_nxt;
      end else begin
        a_cnt_r <= 2'd0;
      end
      b_cnt_r <= a_cnt_r;
      if (b_cnt_r == 2'd2) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(2);
      end else if (b_cnt_r == 2'd1) begin
        wr_ptr_r <= wr_ptr1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_op0_r    <= a_op0_nxt;
      a_op1_r    <= a_op1_nxt;
      a_short0_r <= a_short0_nxt;
      a_fin0_r   <= a_fin0_nxt;
    end
    b_prod0_r  <= PROD_W'(mag0) * PROD_W'(gain_r);
    b_prod1_r  <= PROD_W'(mag1) * PROD_W'(gain_r);
    b_neg0_r   <= a_op0_r[D_W-1];
    b_neg1_r   <= a_op1_r[D_W-1];
    b_short0_r <= a_short0_r;
    b_fin0_r   <= a_fin0_r;
    if (b_cnt_r != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (b_cnt_r == 2'd2) begin
      fifo_r[wr_ptr1] <= res1;
    end
  end

  // ---------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------
  res_t head;
  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {1'b0, head.freq};
  assign out_tuser  = head.too_short;
  assign out_tlast  = head.fin;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FREQ_GAIN) ? 32'(gain_r) : 32'd0;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    pending <= CNT_W'(FIFO_DEPTH))
    else $error("result queue over-committed");

  a_short_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && (out_tdata == 24'd0)))
    else $error("short-sequence result not final or non-zero");

  a_pair_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (a_cnt_r == 2'd2) |-> ($past(idx_r) == IDX_STEADY && idx_r == IDX_FIRST))
    else $error("two results outside a sequence end");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && idx_r != IDX_FIRST) |=> (a_cnt_r != 2'd0))
    else $error("accepted sample produced no result");

endmodule
`default_nettype wire
